// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/arpcg_pkg.sv =====
`default_nettype none
package arpcg_pkg;

  localparam int NUM_IFACES   = 4;
  localparam int SLOT_W       = (NUM_IFACES > 1) ? $clog2(NUM_IFACES) : 1;
  localparam int CNT_W        = $clog2(NUM_IFACES + 1);
  localparam int MAX_RESULTS  = 8;
  localparam int RES_W        = $clog2(MAX_RESULTS + 1);
  localparam int COUNT_W      = 3;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_IFACE_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFEND_TICKS = 1'b1;
  localparam logic [31:0]          DEFEND_RESET     = 32'd10000;
  localparam logic [47:0]          MAC_BCAST        = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_ARP   = 2'd1,
    REQ_TICK  = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ACT_LOCAL   = 3'd0,
    ACT_NONE    = 3'd1,
    ACT_SUPPR   = 3'd2,
    ACT_PASSIVE = 3'd3,
    ACT_REPLY   = 3'd4,
    ACT_GRAT    = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOCAL,
    ST_CONF,
    ST_GRAT,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  entry_index;
    logic [31:0] entry_ip;
    logic [47:0] entry_mac;
    logic        entry_active;
    logic        entry_usable;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
  } req_t;

  typedef struct packed {
    logic [2:0]  action_code;
    logic [1:0]  iface_slot;
    logic [31:0] frame_src_ip;
    logic [47:0] frame_src_mac;
    logic [31:0] frame_dst_ip;
    logic [47:0] frame_dst_mac;
    logic        last_of_run;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/arp_ip_conflict_guard.sv =====
// A table write, a tick or an unknown request is taken without stalling the input.
// An ARP request stalls the input while it walks the n slots in use, first for a local
// match and then for conflicts, answering each active-mode conflict with a reply and a
// gratuitous frame. A local match or a suppressed conflict ends the walk early.
// Output stalls hold the walk. Results leave one by one as the next is made.
// Reset clears the table, the tick counter and the output valid, and restores the registers.
`default_nettype none
module arp_ip_conflict_guard import arpcg_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire req_t                  in_req_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      res_t                  out_res_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  state_e state_q, state_d;
  logic [CNT_W-1:0] idx_q, idx_d, n_q, n_d;
  logic [RES_W-1:0] k_q, k_d;
  logic [31:0] sip_q, sip_d;
  logic [47:0] smac_q, smac_d;
  res_t pend_q, pend_d, out_q, out_d;
  logic pend_vld_q, pend_vld_d, out_vld_q, out_vld_d;

  logic [31:0] ip_q       [NUM_IFACES];
  logic [47:0] mac_q      [NUM_IFACES];
  logic        active_q   [NUM_IFACES];
  logic        usable_q   [NUM_IFACES];
  logic [31:0] last_q     [NUM_IFACES];
  logic        seen_q     [NUM_IFACES];
  logic [31:0] now_q;
  logic [COUNT_W-1:0] count_q;
  logic [31:0] defend_q;

  logic [SLOT_W-1:0] slot;
  logic walk_end, local_hit, conflict, suppress, can_push, can_make;
  logic in_acc, c_sup, c_new, lim_sup, lim_new, rec_tick;
  logic [31:0] elapsed;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_q;

  assign slot      = idx_q[SLOT_W-1:0];
  assign walk_end  = (idx_q >= n_q);
  assign local_hit = usable_q[slot] && (mac_q[slot] == smac_q);
  assign conflict  = usable_q[slot] && (ip_q[slot] == sip_q) && (mac_q[slot] != smac_q);
  assign elapsed   = now_q - last_q[slot];
  assign suppress  = seen_q[slot] && (elapsed < defend_q);
  assign can_push  = !out_vld_q || !out_stall_i;
  assign can_make  = !pend_vld_q || can_push;
  assign c_sup     = (state_q == ST_CONF) && !walk_end && conflict && suppress;
  assign c_new     = (state_q == ST_CONF) && !walk_end && conflict && !suppress;
  assign lim_sup   = (int'(k_q) >= MAX_RESULTS);
  assign lim_new   = ((int'(k_q) + (active_q[slot] ? 2 : 1)) > MAX_RESULTS);
  assign rec_tick  = c_new && !lim_new && can_make;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_req_i.req_type == REQ_ARP)) begin
          state_d = ST_LOCAL;
        end
      end
      ST_LOCAL: begin
        if (walk_end) begin
          state_d = ST_CONF;
        end else if (local_hit) begin
          state_d = ST_FLUSH;
        end
      end
      ST_CONF: begin
        if (walk_end) begin
          state_d = ST_FLUSH;
        end else if (c_sup) begin
          if (lim_sup || can_make) begin
            state_d = ST_FLUSH;
          end
        end else if (c_new) begin
          if (lim_new) begin
            state_d = ST_FLUSH;
          end else if (can_make && active_q[slot]) begin
            state_d = ST_GRAT;
          end
        end
      end
      ST_GRAT: begin
        if (can_make) begin
          state_d = ST_CONF;
        end
      end
      ST_FLUSH: begin
        if (can_push) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    res_t r;
    logic mk;
    r          = '0;
    mk         = 1'b0;
    idx_d      = idx_q;
    n_d        = n_q;
    k_d        = k_q;
    sip_d      = sip_q;
    smac_d     = smac_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && out_stall_i;
    r.iface_slot = 2'(slot);
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_req_i.req_type == REQ_ARP)) begin
          sip_d      = in_req_i.sender_ip;
          smac_d     = in_req_i.sender_mac;
          n_d        = (int'(count_q) > NUM_IFACES) ? CNT_W'(NUM_IFACES) : CNT_W'(count_q);
          idx_d      = '0;
          k_d        = '0;
          pend_vld_d = 1'b0;
        end
      end
      ST_LOCAL: begin
        if (walk_end) begin
          idx_d = '0;
        end else if (local_hit) begin
          r.action_code = ACT_LOCAL;
          pend_d        = r;
          pend_vld_d    = 1'b1;
        end else begin
          idx_d = idx_q + CNT_W'(1);
        end
      end
      ST_CONF: begin
        if (!walk_end) begin
          if (c_sup) begin
            r.action_code = ACT_SUPPR;
            mk = !lim_sup && can_make;
          end else if (c_new) begin
            if (active_q[slot]) begin
              r.action_code   = ACT_REPLY;
              r.frame_src_ip  = ip_q[slot];
              r.frame_src_mac = mac_q[slot];
              r.frame_dst_ip  = sip_q;
              r.frame_dst_mac = smac_q;
            end else begin
              r.action_code = ACT_PASSIVE;
              if (rec_tick) begin
                idx_d = idx_q + CNT_W'(1);
              end
            end
            mk = rec_tick;
          end else begin
            idx_d = idx_q + CNT_W'(1);
          end
        end
      end
      ST_GRAT: begin
        r.action_code   = ACT_GRAT;
        r.frame_src_ip  = ip_q[slot];
        r.frame_src_mac = mac_q[slot];
        r.frame_dst_ip  = ip_q[slot];
        r.frame_dst_mac = MAC_BCAST;
        mk = can_make;
        if (can_make) begin
          idx_d = idx_q + CNT_W'(1);
        end
      end
      ST_FLUSH: begin
        if (can_push) begin
          if (pend_vld_q) begin
            out_d = pend_q;
          end else begin
            out_d = '0;
            out_d.action_code = ACT_NONE;
          end
          out_d.last_of_run = 1'b1;
          out_vld_d  = 1'b1;
          pend_vld_d = 1'b0;
        end
      end
      default: ;
    endcase
    if (mk) begin
      if (pend_vld_q) begin
        out_d             = pend_q;
        out_d.last_of_run = 1'b0;
        out_vld_d         = 1'b1;
      end
      pend_d     = r;
      pend_vld_d = 1'b1;
      k_d        = k_q + RES_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      n_q        <= '0;
      k_q        <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      now_q      <= '0;
      count_q    <= '0;
      defend_q   <= DEFEND_RESET;
      for (int i = 0; i < NUM_IFACES; i++) begin
        ip_q[i]     <= '0;
        mac_q[i]    <= '0;
        active_q[i] <= 1'b0;
        usable_q[i] <= 1'b0;
        last_q[i]   <= '0;
        seen_q[i]   <= 1'b0;
      end
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      n_q        <= n_d;
      k_q        <= k_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_IFACE_COUNT:  count_q  <= cfg_wdata_i[COUNT_W-1:0];
          CFG_DEFEND_TICKS: defend_q <= cfg_wdata_i[31:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        case (in_req_i.req_type)
          REQ_WRITE: begin
            if (int'(in_req_i.entry_index) < NUM_IFACES) begin
              ip_q[SLOT_W'(in_req_i.entry_index)]     <= in_req_i.entry_ip;
              mac_q[SLOT_W'(in_req_i.entry_index)]    <= in_req_i.entry_mac;
              active_q[SLOT_W'(in_req_i.entry_index)] <= in_req_i.entry_active;
              usable_q[SLOT_W'(in_req_i.entry_index)] <= in_req_i.entry_usable;
            end
          end
          REQ_TICK: now_q <= now_q + 32'd1;
          default: ;
        endcase
      end
      if (rec_tick) begin
        last_q[slot] <= now_q;
        seen_q[slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sip_q  <= sip_d;
    smac_q <= smac_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

endmodule
`default_nettype wire

// ===== rtl/arpcg_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module arpcg_checker import arpcg_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_stall_o,
  input wire req_t                  in_req_i,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire res_t                  out_res_o
);

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_res_o))
  `ASSERT_NEXT(a_arp_busy, clk_i, rst_ni,
               in_valid_i && !in_stall_o && (in_req_i.req_type == REQ_ARP), in_stall_o)
  `ASSERT_IMPLY(a_run_open, clk_i, rst_ni, out_valid_o && !out_res_o.last_of_run, in_stall_o)

endmodule

bind arp_ip_conflict_guard arpcg_checker u_arpcg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_res_o   (out_res_o)
);
`default_nettype wire
